[rtl/mcg_pkg.sv]
// shared types, register indexes and helpers for the multi-click gesture detector
`timescale 1ns / 1ps
package mcg_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_WATCHED_SIGNAL = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TRIGGER_VALUE  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_WINDOW_MS      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_HOLD_MS    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MIN_GAP_MS     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ACTION_MAP     = 3'd5;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam int MapW = 10;
	localparam int WinUsW = 24;
	localparam int GapUsW = 26;
	localparam int TimeW = 64;

	localparam logic [9:0] US_PER_MS = 10'd1000;

	// reset values of the derived thresholds (ms * 1000)
	localparam logic [WinUsW-1:0] WINDOW_US_RST = 24'd1000000;
	localparam logic [GapUsW-1:0] HOLD_US_RST   = 26'd600000;
	localparam logic [GapUsW-1:0] GAP_US_RST    = 26'd60000;

	typedef struct packed {
		logic [7:0]        watched_signal;
		logic [7:0]        trigger_value;
		logic [WinUsW-1:0] window_us;
		logic [GapUsW-1:0] hold_us;
		logic [GapUsW-1:0] gap_us;
		logic [MapW-1:0]   action_map;
		logic [3:0]        top_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0] click_count;
		logic       has_action;
	} result_t;

	// highest click count with a mapped action, zero when the map is empty
	function automatic logic [3:0] highest_mapped(input logic [MapW-1:0] map);
		logic [3:0] top;
		top = 4'd0;
		for (int k = 1; k <= MapW; k++) begin
			if (map[k-1]) top = 4'(k);
		end
		return top;
	endfunction

endpackage

[rtl/mcg_cfg.sv]
// configuration registers with precomputed microsecond thresholds
`timescale 1ns / 1ps
module mcg_cfg
	import mcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watched_signal <= 8'd0;
			cfg_q.trigger_value  <= 8'd1;
			cfg_q.window_us      <= WINDOW_US_RST;
			cfg_q.hold_us        <= HOLD_US_RST;
			cfg_q.gap_us         <= GAP_US_RST;
			cfg_q.action_map     <= '0;
			cfg_q.top_count      <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WATCHED_SIGNAL: cfg_q.watched_signal <= cfg_data[7:0];
				REG_TRIGGER_VALUE:  cfg_q.trigger_value <= cfg_data[7:0];
				REG_WINDOW_MS:      cfg_q.window_us <= WinUsW'(cfg_data[13:0]) * WinUsW'(US_PER_MS);
				REG_MAX_HOLD_MS:    cfg_q.hold_us <= GapUsW'(cfg_data) * GapUsW'(US_PER_MS);
				REG_MIN_GAP_MS:     cfg_q.gap_us <= GapUsW'(cfg_data) * GapUsW'(US_PER_MS);
				REG_ACTION_MAP: begin
					cfg_q.action_map <= cfg_data[MapW-1:0];
					cfg_q.top_count  <= highest_mapped(cfg_data[MapW-1:0]);
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/mcg_core.sv]
// click tracking state and per-item decision logic
`timescale 1ns / 1ps
module mcg_core
	import mcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             en,
	input  logic             command,
	input  logic [7:0]       signal_id,
	input  logic [7:0]       value_code,
	input  logic [TimeW-1:0] time_us,
	output logic             res_valid,
	output result_t          res
);

	logic             baseline_q;
	logic [7:0]       last_value_q;
	logic             pressed_q;
	logic [TimeW-1:0] press_time_q;
	logic [7:0]       count_q;
	logic [TimeW-1:0] release_time_q;
	logic             fire_q;

	logic             baseline_d;
	logic [7:0]       last_value_d;
	logic             pressed_d;
	logic [TimeW-1:0] press_time_d;
	logic [7:0]       count_d;
	logic [TimeW-1:0] release_time_d;
	logic             fire_d;

	logic [TimeW-1:0] hold_diff;
	logic [TimeW-1:0] rel_diff;
	logic [7:0]       count_inc;
	logic             go;
	logic             is_trig;
	logic [3:0]       map_idx;

	assign hold_diff = time_us - press_time_q;
	assign rel_diff  = time_us - release_time_q;
	assign count_inc = (count_q == 8'hff) ? count_q : count_q + 8'd1;
	assign is_trig   = (value_code == cfg.trigger_value);
	assign map_idx   = 4'(count_q - 8'd1);

	always_comb begin
		baseline_d     = baseline_q;
		last_value_d   = last_value_q;
		pressed_d      = pressed_q;
		press_time_d   = press_time_q;
		count_d        = count_q;
		release_time_d = release_time_q;
		fire_d         = fire_q;
		res_valid      = 1'b0;
		res.click_count = count_q;
		res.has_action  = (count_q >= 8'd1 && count_q <= 8'd10) ? cfg.action_map[map_idx] : 1'b0;
		go             = 1'b0;

		if (command == CMD_SAMPLE) begin
			if (signal_id == cfg.watched_signal) begin
				if (!baseline_q) begin
					baseline_d   = 1'b1;
					last_value_d = value_code;
					go           = is_trig;
				end else if (value_code != last_value_q) begin
					last_value_d = value_code;
					go           = 1'b1;
				end
			end
			if (go) begin
				if (is_trig) begin
					pressed_d    = 1'b1;
					press_time_d = time_us;
				end else if (pressed_q) begin
					pressed_d = 1'b0;
					if (hold_diff > TimeW'(cfg.hold_us)) begin
						count_d = 8'd0;
						fire_d  = 1'b0;
					end else if (!(count_q != 8'd0 && rel_diff < TimeW'(cfg.gap_us))) begin
						count_d        = count_inc;
						release_time_d = time_us;
						if (cfg.top_count != 4'd0 && count_inc >= 8'(cfg.top_count))
							fire_d = 1'b1;
					end
				end
			end
		end else begin
			if (count_q != 8'd0 && !pressed_q &&
				(fire_q || rel_diff >= TimeW'(cfg.window_us))) begin
				res_valid = 1'b1;
				fire_d    = 1'b0;
				count_d   = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q     <= 1'b0;
			last_value_q   <= 8'd0;
			pressed_q      <= 1'b0;
			press_time_q   <= '0;
			count_q        <= 8'd0;
			release_time_q <= '0;
			fire_q         <= 1'b0;
		end else if (en) begin
			baseline_q     <= baseline_d;
			last_value_q   <= last_value_d;
			pressed_q      <= pressed_d;
			press_time_q   <= press_time_d;
			count_q        <= count_d;
			release_time_q <= release_time_d;
			fire_q         <= fire_d;
		end
	end

	a_fire_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire_q |-> count_q != 8'd0)
		else $error("fire pending with empty count");

	a_press_after_baseline: assert property (@(posedge clk) disable iff (!arst_n)
		pressed_q |-> baseline_q)
		else $error("press recorded before baseline");

	a_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res_valid) |=> (count_q == 8'd0 && !fire_q))
		else $error("count not cleared after result");

endmodule

[rtl/multi_click_gesture_detector.sv]
// top level: input register, click logic, result register and handshakes
// an accepted item is held in the input register, evaluated from there by the
//   click logic once the result register is free, and its result registered
// throughput: one item per cycle, held back only while a result waits unread
// reset: arst_n asynchronously resets all but the data registers to defaults
`timescale 1ns / 1ps
module multi_click_gesture_detector
	import mcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [79:0]         s_tdata,  // signal_id, value_code, time_us
	input  logic                s_tuser,  // command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // click_count
	output logic                m_tuser,  // has_action
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t             cfg;
	logic             valid_s1;
	logic             command_s1;
	logic [7:0]       signal_id_s1;
	logic [7:0]       value_code_s1;
	logic [TimeW-1:0] time_us_s1;
	logic             advance;
	logic             res_valid;
	result_t          res;
	logic             m_valid_q;
	result_t          m_res_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1    <= s_tuser;
			signal_id_s1  <= s_tdata[7:0];
			value_code_s1 <= s_tdata[15:8];
			time_us_s1    <= s_tdata[79:16];
		end
	end

	mcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (advance),
		.command    (command_s1),
		.signal_id  (signal_id_s1),
		.value_code (value_code_s1),
		.time_us    (time_us_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= res_valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) m_res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_res_q.click_count;
	assign m_tuser  = m_res_q.has_action;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 8'd0)
		else $error("result with zero clicks");

	a_action_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata <= 8'd10)
		else $error("action flagged for unmapped count");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !m_valid_q) |-> s_tready)
		else $error("input stalled with free room");

endmodule

[tb/sv/tb.sv]
// testbench for the multi-click gesture detector: directed table, random click runs, scoreboard
`timescale 1ns / 1ps
module tb
	import mcg_pkg::*;
();

	localparam int LIMIT_CYCLES = 200000;
	localparam int ITEM_TARGET = 1250;
	localparam int CALM_FROM = 1120;
	localparam int SQUEEZE_CYCLES = 300;
	localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic       cmd;
		logic [7:0] sig;
		logic [7:0] val;
		logic [63:0] t;
		bit         typed;
		bit         fires;
		logic [7:0] count;
		logic       act;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [79:0]         s_tdata;  // signal_id, value_code, time_us
	logic                s_tuser;  // command
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;  // click_count
	logic                m_tuser;  // has_action
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	multi_click_gesture_detector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copy
	logic [7:0]  watch_id = 8'd0;
	logic [7:0]  trig_code = 8'd1;
	logic [13:0] win_ms = 14'd1000;
	logic [15:0] hold_ms = 16'd600;
	logic [15:0] gap_ms = 16'd60;
	logic [9:0]  map_bits = 10'd0;

	// click tracker state
	bit          seen_base = 1'b0;
	logic [7:0]  prev_val = 8'd0;
	bit          pressed = 1'b0;
	logic [63:0] t_press = 64'd0;
	logic [7:0]  n_clicks = 8'd0;
	logic [63:0] t_release = 64'd0;
	bit          fire_pending = 1'b0;

	result_t     fired_q[$];
	result_t     want;
	dir_row_t    dir_rows [26];

	int n_errors = 0;
	int n_items = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_writes = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit squeeze_req = 1'b0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, fired_q.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (squeeze_req) begin
					squeeze_req = 1'b0;
					stall_left = SQUEEZE_CYCLES;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 4);
				end
			end
			if (stall_left != 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (fired_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, got click_count=%0d has_action=%0d",
					$time, m_tdata, m_tuser);
			end else begin
				want = fired_q.pop_front();
				n_results++;
				if (m_tdata !== want.click_count) begin
					n_errors++;
					$display("%0t: click_count mismatch, expected %0d, got %0d",
						$time, want.click_count, m_tdata);
				end
				if (m_tuser !== want.has_action) begin
					n_errors++;
					$display("%0t: has_action mismatch, expected %0d, got %0d",
						$time, want.has_action, m_tuser);
				end
			end
		end
	end

	task automatic track_item(input logic cmd, input logic [7:0] sig, input logic [7:0] val,
			input logic [63:0] t, output bit fires, output result_t res);
		logic [3:0] top;
		fires = 1'b0;
		res = '0;
		if (cmd == CMD_SAMPLE) begin
			if (sig != watch_id) return;
			if (!seen_base) begin
				seen_base = 1'b1;
				prev_val = val;
				if (val != trig_code) return;
			end else begin
				if (val == prev_val) return;
				prev_val = val;
			end
			if (val == trig_code) begin
				pressed = 1'b1;
				t_press = t;
				return;
			end
			if (!pressed) return;
			pressed = 1'b0;
			if (t - t_press > 64'(hold_ms) * 64'd1000) begin
				n_clicks = 8'd0;
				fire_pending = 1'b0;
				return;
			end
			if (n_clicks != 8'd0 && (t - t_release) < 64'(gap_ms) * 64'd1000) return;
			if (n_clicks != 8'd255) n_clicks++;
			t_release = t;
			top = 4'd0;
			for (int k = 1; k <= 10; k++) begin
				if (map_bits[k-1]) top = 4'(k);
			end
			if (top != 4'd0 && n_clicks >= 8'(top)) fire_pending = 1'b1;
			return;
		end
		if (n_clicks == 8'd0 || pressed) return;
		if (!fire_pending && (t - t_release) < 64'(win_ms) * 64'd1000) return;
		fire_pending = 1'b0;
		res.click_count = n_clicks;
		res.has_action = (n_clicks >= 8'd1 && n_clicks <= 8'd10) ? map_bits[n_clicks-8'd1] : 1'b0;
		n_clicks = 8'd0;
		fires = 1'b1;
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input logic cmd, input logic [7:0] sig, input logic [7:0] val,
			input logic [63:0] t, input bit typed, input bit typed_fires, input result_t typed_res);
		bit fires;
		result_t res;
		if (n_items >= CALM_FROM) calm = 1'b1;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {t, val, sig};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_TICK || sig == watch_id) n_items++;
		n_sent++;
		track_item(cmd, sig, val, t, fires, res);
		if (typed) begin
			if (typed_fires) fired_q = {fired_q, typed_res};
		end else if (fires) begin
			fired_q = {fired_q, res};
		end
		@(negedge clk);
	endtask

	task automatic put_sample(input logic [7:0] sig, input logic [7:0] val, input logic [63:0] t);
		send_item(CMD_SAMPLE, sig, val, t, 1'b0, 1'b0, '0);
	endtask

	task automatic put_tick(input logic [63:0] t);
		send_item(CMD_TICK, 8'($urandom), 8'($urandom), t, 1'b0, 1'b0, '0);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (fired_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		n_writes++;
		case (idx)
			REG_WATCHED_SIGNAL: watch_id = d[7:0];
			REG_TRIGGER_VALUE:  trig_code = d[7:0];
			REG_WINDOW_MS:      win_ms = d[13:0];
			REG_MAX_HOLD_MS:    hold_ms = d[15:0];
			REG_MIN_GAP_MS:     gap_ms = d[15:0];
			REG_ACTION_MAP:     map_bits = d[9:0];
			default: ;
		endcase
	endtask

	task automatic load_cfg(input logic [15:0] watch, input logic [15:0] trig,
			input logic [15:0] win, input logic [15:0] hold, input logic [15:0] gap,
			input logic [15:0] map);
		drain();
		write_reg(REG_WATCHED_SIGNAL, watch);
		write_reg(REG_TRIGGER_VALUE, trig);
		write_reg(REG_WINDOW_MS, win);
		write_reg(REG_MAX_HOLD_MS, hold);
		write_reg(REG_MIN_GAP_MS, gap);
		write_reg(REG_ACTION_MAP, map);
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
		cfg_we = 1'b0;
	endtask

	task automatic noise_item(input logic [63:0] t);
		case ($urandom_range(0, 4))
			0: put_sample(watch_id + 8'($urandom_range(1, 255)), 8'($urandom), {$urandom, $urandom});
			1: put_sample(watch_id, prev_val, t);
			2: put_tick(t);
			3: send_item(1'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom},
				1'b0, 1'b0, '0);
			default: put_sample(watch_id, 8'($urandom), t);
		endcase
	endtask

	// press/release pairs with holds and gaps around the thresholds, then ticks
	task automatic click_run();
		int unsigned n, hold_us, gap_us, win_us;
		logic [63:0] t, t_rel;
		logic [7:0] rv;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
		hold_us = 32'(hold_ms) * 1000;
		gap_us = 32'(gap_ms) * 1000;
		win_us = 32'(win_ms) * 1000;
		if ($urandom_range(0, 7) == 0)
			t = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20000000));
		else
			t = {$urandom, $urandom};
		t_rel = t;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 5) == 0) noise_item(t);
			put_sample(watch_id, trig_code, t);
			case ($urandom_range(0, 9))
				0: t += 64'(hold_us) + 64'($urandom_range(1, 3000));
				1: t += 64'(hold_us);
				default: t += 64'($urandom_range(0, hold_us));
			endcase
			if ($urandom_range(0, 7) == 0) noise_item(t);
			rv = trig_code + 8'($urandom_range(1, 255));
			put_sample(watch_id, rv, t);
			t_rel = t;
			if ($urandom_range(0, 4) == 0)
				t += 64'($urandom_range(0, gap_us));
			else
				t += 64'(gap_us) + 64'($urandom_range(0, 40000));
		end
		case ($urandom_range(0, 3))
			0: begin
				put_tick(t_rel + 64'(win_us) - 64'd1);
				put_tick(t_rel + 64'(win_us));
			end
			1: put_tick(t_rel + 64'(win_us));
			2: put_tick(t_rel + 64'($urandom_range(0, 2 * win_us)));
			default: begin
				put_tick(t_rel + 64'($urandom_range(0, win_us)));
				put_tick(t_rel + 64'(win_us) + 64'($urandom_range(0, 1000)));
			end
		endcase
	endtask

	task automatic run_phase(input int budget);
		int start;
		start = n_items;
		while (n_items - start < budget) click_run();
	endtask

	initial begin
		logic [63:0] t;
		result_t tr;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dir_rows = '{
			'{CMD_TICK,   8'd0,   8'd0,   64'd0,          1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd255, 8'd1,   64'd0,          1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd1000,       1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd2000,       1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd3000,       1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd101000,     1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd111000,     1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd121000,     1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd500000,     1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd1101000,    1'b1, 1'b1, 8'd1, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd2000000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd3000000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd3100000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd3200000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd3800001,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd9000000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd255, 64'd9500000,    1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd10000000,   1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd10600000,   1'b0, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'd10660000,   1'b0, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd2,   64'd10700000,   1'b0, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd11699999,   1'b0, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd11700000,   1'b0, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_SAMPLE, 8'd0,   8'd0,   64'd99999,      1'b1, 1'b0, 8'd0, 1'b0},
			'{CMD_TICK,   8'd0,   8'd0,   64'd1099999,    1'b1, 1'b1, 8'd1, 1'b0}
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			tr.click_count = dir_rows[i].count;
			tr.has_action = dir_rows[i].act;
			send_item(dir_rows[i].cmd, dir_rows[i].sig, dir_rows[i].val, dir_rows[i].t,
				dir_rows[i].typed, dir_rows[i].fires, tr);
		end

		load_cfg(16'h003C, 16'h0055, 16'd100, 16'd200, 16'd30, 16'h0004);
		run_phase(120);
		// window written as zero through masked upper bits, full map, longest hold
		load_cfg(16'hFFFF, 16'hFF00, 16'hC000, 16'hFFFF, 16'h0000, 16'hFFFF);
		run_phase(120);
		load_cfg(16'h0000, 16'h00FF, 16'd10000, 16'd0, 16'hFFFF, 16'h0200);
		run_phase(120);
		// single-click map fires on every click; receiver holds off meanwhile
		load_cfg(16'h0081, 16'h007E, 16'h3FFF, 16'd1000, 16'd100, 16'h0001);
		squeeze_req = 1'b1;
		run_phase(120);

		// counter saturation
		load_cfg(16'h0012, 16'h0001, 16'd500, 16'd300, 16'd0, 16'h0000);
		t = {$urandom, $urandom};
		for (int k = 0; k < 258; k++) begin
			put_sample(watch_id, 8'h01, t);
			t += 64'd1000;
			put_sample(watch_id, 8'h02, t);
			t += 64'd1000;
		end
		put_tick(t + 64'd500000);

		while (n_items < ITEM_TARGET) begin
			load_cfg(16'($urandom), 16'($urandom),
				{2'($urandom), 14'($urandom_range(100, 10000))},
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500)),
				16'($urandom));
			run_phase(100);
		end

		drain();
		repeat (4) @(negedge clk);
		$display("run covered %0d transfers in (%0d acted on), %0d results checked, %0d register writes",
			n_sent, n_items, n_results, n_writes);
		$display("click runs over %0d settings incl. zero window, hold and gap extremes, saturation",
			(n_writes / 7));
		if (n_errors == 0 && fired_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/mcg_pkg.sv
rtl/mcg_cfg.sv
rtl/mcg_core.sv
rtl/multi_click_gesture_detector.sv
tb/sv/tb.sv
